@@ hw/rtl/pkc_pkg.sv @@
// Shared types, character constants and the scheme table for the path key canonicalizer.
package pkc_pkg;

    // Prefix and result list sizes
    localparam int unsigned PREFIX_LEN = 7;
    localparam int unsigned MAX_RES    = 7;
    localparam logic [2:0]  PREFIX_END = 3'(PREFIX_LEN);
    localparam logic [2:0]  RES_FULL   = 3'(MAX_RES);

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CASE_OFFSET = CH_LC_A - CH_UC_A;

    // Where the key is within its leading part
    typedef enum logic [1:0] {
        ST_PREFIX = 2'd0,
        ST_START  = 2'd1,
        ST_BODY   = 2'd2
    } t_stage;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_out_item;

    // All results caused by one input item
    typedef struct packed {
        t_out_item [MAX_RES-1:0] item;
        logic [2:0]              count;
    } t_res_list;

    // Per-key scanning state
    typedef struct packed {
        logic [2:0] matched;
        t_stage     stage;
        logic       dot_pending;
        logic       slash_held;
    } t_state;

    // "file://" one byte at a time
    function automatic logic [7:0] scheme_byte(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3A;
            3'd5:    c = CH_SLASH;
            3'd6:    c = CH_SLASH;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/path_key_canonicalizer_top.sv @@
// Path key canonicalizer top level: input register, scan state, transform and result stream.
// An item is held in the input register; its results then pass the list buffer and the output register.
// Throughput: one item per cycle while items give at most one result each and the output is
//   not stalled; an item with n results (n up to 7, on a prefix flush) holds back the next item.
// The result list buffer and output register let the next item enter while a result waits.
// Reset (synchronous, active low) clears the scan state and empties every stage.
module path_key_canonicalizer_top
    import pkc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_vld;
    t_in_item  r_in;
    t_state    r_st;
    t_state    n_st;
    t_res_list n_list;
    logic      list_free;
    logic      list_take;

    // Input register hands over when the list buffer can take the results
    assign list_take  = r_in_vld && list_free;
    assign o_in_stall = r_in_vld && !list_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (list_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // Scan state advances once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{matched: 3'd0, stage: ST_PREFIX, dot_pending: 1'b0, slash_held: 1'b0};
        end else if (list_take) begin
            r_st <= n_st;
        end
    end

    pkc_xform u_xform (
        .i_state (r_st),
        .i_item  (r_in),
        .o_state (n_st),
        .o_list  (n_list)
    );

    pkc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (list_take),
        .i_list      (n_list),
        .o_free      (list_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // A partial prefix match exists only in the prefix stage
    a_match_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.matched != 3'd0) |-> (r_st.stage == ST_PREFIX && r_st.matched != PREFIX_END))
        else $error("prefix match count outside prefix stage");

    // A held dot lives only in the body stage and never with a held slash
    a_dot_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.dot_pending |-> (r_st.stage == ST_BODY && !r_st.slash_held))
        else $error("held dot in wrong stage");

    // A held slash lives only in the body stage
    a_slash_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.slash_held |-> (r_st.stage == ST_BODY))
        else $error("held slash in wrong stage");

endmodule

@@ hw/rtl/pkc_xform.sv @@
// Per-item transform: maps one key byte and the scan state to next state and result list.
module pkc_xform
    import pkc_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_res_list o_list
);

    typedef struct packed {
        t_res_list l;
        logic      sl;
    } t_work;

    // Append one byte result, capped at the list size
    function automatic t_res_list put(input t_res_list l, input logic [7:0] c);
        t_res_list r;
        r = l;
        if (r.count != RES_FULL) begin
            r.item[r.count] = '{out_byte: c, has_byte: 1'b1, out_last: 1'b0};
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    // Body byte: slashes merge into one held slash
    function automatic t_work body(input t_work w, input logic [7:0] c);
        t_work r;
        r = w;
        if (c == CH_SLASH) begin
            r.sl = 1'b1;
        end else begin
            if (r.sl) begin
                r.l  = put(r.l, CH_SLASH);
                r.sl = 1'b0;
            end
            r.l = put(r.l, c);
        end
        return r;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic [2:0] nflush;
        logic       match;
        logic       do_flush;
        t_work      w;
        t_state     s;

        // Byte mapping: backslash to slash, upper to lower case
        b = i_item.in_byte;
        if (b == CH_BSLASH) begin
            b = CH_SLASH;
        end else if (b >= CH_UC_A && b <= CH_UC_Z) begin
            b = b + CASE_OFFSET;
        end

        s        = i_state;
        w.l      = '0;
        w.sl     = i_state.slash_held;
        nflush   = '0;
        do_flush = 1'b0;
        match    = (s.matched != PREFIX_END) && (b == scheme_byte(s.matched));

        unique case (s.stage)
            ST_PREFIX: begin
                if (match) begin
                    s.matched = s.matched + 3'd1;
                    if (s.matched == PREFIX_END) begin
                        s.matched = '0;
                        s.stage   = ST_START;
                    end else if (i_item.in_last) begin
                        // key ends inside a partial match: held bytes are content
                        nflush   = s.matched;
                        do_flush = 1'b1;
                    end
                end else if (s.matched == '0) begin
                    s.stage = ST_BODY;
                    if (b == CH_DOT) begin
                        s.dot_pending = 1'b1;
                    end else begin
                        w = body(w, b);
                    end
                end else begin
                    nflush   = s.matched;
                    do_flush = 1'b1;
                end
            end
            ST_START: begin
                s.stage = ST_BODY;
                if (b == CH_DOT) begin
                    s.dot_pending = 1'b1;
                end else begin
                    w = body(w, b);
                end
            end
            default: begin
                if (s.dot_pending) begin
                    s.dot_pending = 1'b0;
                    if (b == CH_SLASH) begin
                        w.sl = 1'b1;
                    end else begin
                        w.l = put(w.l, CH_DOT);
                        w   = body(w, b);
                    end
                end else begin
                    w = body(w, b);
                end
            end
        endcase

        // Re-emit held prefix bytes; on a mismatch the byte follows them
        if (do_flush) begin
            for (int i = 0; i < PREFIX_LEN; i++) begin
                if (3'(i) < nflush) begin
                    w = body(w, scheme_byte(3'(i)));
                end
            end
            if (!match) begin
                w = body(w, b);
            end
            s.matched = '0;
            s.stage   = ST_BODY;
        end

        // End of key: release held dot and slash, mark the final result
        if (i_item.in_last) begin
            if (s.dot_pending) begin
                w = body(w, CH_DOT);
            end
            if (w.sl) begin
                w.l  = put(w.l, CH_SLASH);
                w.sl = 1'b0;
            end
            if (w.l.count == '0) begin
                w.l.item[0] = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b0};
                w.l.count   = 3'd1;
            end
            w.l.item[w.l.count - 3'd1].out_last = 1'b1;
            s = '{matched: 3'd0, stage: ST_PREFIX, dot_pending: 1'b0, slash_held: 1'b0};
        end else begin
            s.slash_held = w.sl;
        end

        o_state = s;
        o_list  = w.l;
    end

endmodule

@@ hw/rtl/pkc_outq.sv @@
// Result list buffer and output register: streams an item's results one per cycle unless stalled.
module pkc_outq
    import pkc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_list i_list,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_out_item [MAX_RES-1:0] r_q;
    logic [2:0]              r_left;
    logic [2:0]              r_rd;
    logic                    r_ov;
    t_out_item               r_o;
    logic                    oreg_free;
    logic                    pop;

    // Output register takes a new result when empty or being taken
    assign oreg_free = !r_ov || !i_out_stall;
    assign pop       = (r_left != '0) && oreg_free;
    assign o_free    = (r_left == '0) || ((r_left == 3'd1) && pop);

    // List buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rd   <= '0;
        end else if (i_push) begin
            r_left <= i_list.count;
            r_rd   <= '0;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
            r_rd   <= r_rd + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q <= i_list.item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (oreg_free) begin
            r_ov <= (r_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o <= r_q[r_rd];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_o;

    // New list only into a buffer that is empty or draining its last result
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free)
        else $error("result list overwritten");

    // Read index never runs past the list
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (({1'b0, r_rd} + {1'b0, r_left}) <= {1'b0, RES_FULL}))
        else $error("result read index out of range");

    // The empty-key marker is always a final result with a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o.has_byte) |-> (r_o.out_last && (r_o.out_byte == 8'h00)))
        else $error("malformed empty-key marker");

endmodule

@@ sim/path_key_canonicalizer_checker.sv @@
// Checker for the path key canonicalizer: predicts the canonical key stream and compares it.
module path_key_canonicalizer_checker
    import pkc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_err_count = 0,
    output int        o_pending = 0
);

    // "file://", first character in the top byte
    localparam logic [8*PREFIX_LEN-1:0] SCHEME_STR = "file://";

    // Predictor scan state
    logic [2:0] held_cnt;
    t_stage     phase;
    logic       dot_held;
    logic       slash_held;

    // Results of the item being predicted
    t_out_item   step_res [MAX_RES];
    int unsigned step_cnt;

    // Expected canonical key results, oldest first
    t_out_item   canon_bytes_q [$];
    int          errs = 0;

    function automatic logic [7:0] scheme_char(input int unsigned idx);
        return SCHEME_STR[8*(PREFIX_LEN-1-idx) +: 8];
    endfunction

    task automatic put_res(input logic [7:0] b, input logic has);
        if (step_cnt < MAX_RES) begin
            step_res[step_cnt].out_byte = has ? b : 8'h00;
            step_res[step_cnt].has_byte = has;
            step_res[step_cnt].out_last = 1'b0;
            step_cnt++;
        end
    endtask

    // Body byte: slashes are held and merged, anything else flushes a held slash
    task automatic body_char(input logic [7:0] b);
        if (b == CH_SLASH) begin
            slash_held = 1'b1;
        end else begin
            if (slash_held) begin
                put_res(CH_SLASH, 1'b1);
                slash_held = 1'b0;
            end
            put_res(b, 1'b1);
        end
    endtask

    // Re-emit the partly matched scheme bytes as content
    task automatic release_prefix();
        for (int unsigned i = 0; i < held_cnt; i++)
            body_char(scheme_char(i));
        held_cnt = 3'd0;
    endtask

    // First content byte: a leading dot is held to see if a slash follows
    task automatic first_content(input logic [7:0] b);
        phase = ST_BODY;
        if (b == CH_DOT)
            dot_held = 1'b1;
        else
            body_char(b);
    endtask

    task automatic canonicalize_byte(input t_in_item it);
        logic [7:0] b;
        b = it.in_byte;
        step_cnt = 0;
        if (b == CH_BSLASH)
            b = CH_SLASH;
        else if (b >= CH_UC_A && b <= CH_UC_Z)
            b = b + CASE_OFFSET;

        case (phase)
            ST_PREFIX: begin
                if (b == scheme_char(held_cnt)) begin
                    if (held_cnt == PREFIX_END - 3'd1) begin
                        held_cnt = 3'd0;
                        phase    = ST_START;
                    end else begin
                        held_cnt++;
                    end
                end else if (held_cnt == 3'd0) begin
                    first_content(b);
                end else begin
                    release_prefix();
                    phase = ST_BODY;
                    body_char(b);
                end
            end
            ST_START: first_content(b);
            default: begin
                if (dot_held) begin
                    dot_held = 1'b0;
                    if (b == CH_SLASH) begin
                        slash_held = 1'b1;
                    end else begin
                        put_res(CH_DOT, 1'b1);
                        body_char(b);
                    end
                end else begin
                    body_char(b);
                end
            end
        endcase

        // End of key: flush whatever is held, mark the final result, clear state
        if (it.in_last) begin
            if (phase == ST_PREFIX)
                release_prefix();
            if (dot_held) begin
                dot_held = 1'b0;
                body_char(CH_DOT);
            end
            if (slash_held) begin
                put_res(CH_SLASH, 1'b1);
                slash_held = 1'b0;
            end
            if (step_cnt == 0)
                put_res(8'h00, 1'b0);
            step_res[step_cnt-1].out_last = 1'b1;
            phase    = ST_PREFIX;
            held_cnt = 3'd0;
        end

        for (int unsigned i = 0; i < step_cnt; i++)
            canon_bytes_q = {canon_bytes_q, step_res[i]};
    endtask

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            held_cnt   = 3'd0;
            phase      = ST_PREFIX;
            dot_held   = 1'b0;
            slash_held = 1'b0;
            canon_bytes_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (canon_bytes_q.size() == 0) begin
                    $display("%0t: unexpected result: byte %02h has %0b last %0b", $time,
                             i_out_item.out_byte, i_out_item.has_byte,
                             i_out_item.out_last);
                    errs++;
                end else begin
                    want = canon_bytes_q.pop_front();
                    if (i_out_item.out_byte !== want.out_byte
                            || i_out_item.has_byte !== want.has_byte
                            || i_out_item.out_last !== want.out_last) begin
                        $display("%0t: mismatch: expected byte %02h has %0b last %0b, %s",
                                 $time, want.out_byte, want.has_byte, want.out_last,
                                 $sformatf("got byte %02h has %0b last %0b",
                                           i_out_item.out_byte, i_out_item.has_byte,
                                           i_out_item.out_last));
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                canonicalize_byte(i_in_item);
        end
        o_err_count <= errs;
        o_pending   <= canon_bytes_q.size();
    end

endmodule

@@ sim/tb_path_key_canonicalizer_top.sv @@
// Testbench top for the path key canonicalizer: clock, reset, key stimulus, receiver and verdict.
module tb_path_key_canonicalizer_top
    import pkc_pkg::*;
();

    localparam int RAND_ITEMS = 420;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 200;
    localparam int DRAIN      = 16;
    localparam int LIMIT      = 200000;
    localparam logic [8*PREFIX_LEN-1:0] SCHEME_STR = "file://";

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item  = '0;
    logic      out_valid;
    logic      out_stall = 1'b1;
    t_out_item out_item;
    int        err_count;
    int        pending;

    logic       hold_req = 1'b0;
    int         cyc = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    logic [7:0] key_buf [$];

    path_key_canonicalizer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    path_key_canonicalizer_checker i_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("tb_path_key_canonicalizer_top NOT OK");
            $finish;
        end
    end

    // Receiver: stall mode changes now and then, plus one long hold-off
    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge clk) begin
        logic nxt;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b1;
        end else begin
            case (rx_mode)
                0:       nxt = 1'b0;
                1:       nxt = ($urandom_range(0, 3) == 0);
                2:       nxt = ($urandom_range(0, 9) < 7);
                default: nxt = (rx_left % 3 == 0);
            endcase
        end
        out_stall <= nxt;
    end

    // Offer one item; bursts of random length with random gaps between them
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid        <= 1'b1;
        in_item.in_byte <= b;
        in_item.in_last <= last;
        do @(posedge clk); while (in_stall);
        burst_left--;
        items_sent++;
        if (items_sent >= HOLD_AT)
            hold_req <= 1'b1;
    endtask

    task automatic send_key();
        for (int i = 0; i < key_buf.size(); i++)
            send_item(key_buf[i], i == key_buf.size() - 1);
    endtask

    task automatic send_str(input string s);
        key_buf.delete();
        for (int i = 0; i < s.len(); i++)
            key_buf = {key_buf, s[i]};
        send_key();
    endtask

    // Body character: slash, backslash, dot, letter, byte just outside A-Z, any byte
    function automatic logic [7:0] path_char();
        case ($urandom_range(0, 7))
            0:       return CH_SLASH;
            1:       return CH_BSLASH;
            2:       return CH_DOT;
            3:       return CH_LC_A + 8'($urandom_range(0, 25));
            4:       return CH_UC_A + 8'($urandom_range(0, 25));
            5:       return $urandom_range(0, 1) ? CH_UC_A - 8'd1 : CH_UC_Z + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed keys: scheme (full or partial, mixed forms), dot lead-in, body
    task automatic random_key();
        int kind;
        int plen;
        int n;
        logic [7:0] c;
        key_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            n = $urandom_range(1, 6);
            repeat (n) key_buf = {key_buf, 8'($urandom)};
        end else begin
            plen = (kind < 5) ? PREFIX_LEN : $urandom_range(0, PREFIX_LEN - 1);
            for (int j = 0; j < plen; j++) begin
                c = SCHEME_STR[8*(PREFIX_LEN-1-j) +: 8];
                if ($urandom_range(0, 1)) begin
                    if (c == CH_SLASH)
                        c = CH_BSLASH;
                    else if (c >= CH_LC_A)
                        c = c - CASE_OFFSET;
                end
                key_buf = {key_buf, c};
            end
            case ($urandom_range(0, 3))
                0: key_buf = {key_buf, CH_DOT};
                1: begin
                    key_buf = {key_buf, CH_DOT};
                    key_buf = {key_buf, ($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH)};
                end
                default: ;
            endcase
            n = $urandom_range(0, 8);
            repeat (n) key_buf = {key_buf, path_char()};
            if (key_buf.size() == 0)
                key_buf = {key_buf, path_char()};
        end
        send_key();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed keys: byte extremes, scheme only (empty key), last byte inside
        // the scheme, late scheme mismatch, dropped leading dot, kept dot and slash run
        key_buf = '{8'h00, 8'hFF};
        send_key();
        send_str("FILE:\\\\");
        send_str("fi");
        send_str("FiLe:\\X");
        send_str("./a");
        send_str(".a//");

        while (items_sent < RAND_ITEMS)
            random_key();
        in_valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("tb_path_key_canonicalizer_top OK");
        else
            $display("tb_path_key_canonicalizer_top NOT OK");
        $finish;
    end

endmodule
